// ===== sv/distributed_delay_stage_chain_top_macros.svh =====
// Assertion macros for the distributed delay stage chain.
// Used by the top-level module, which carries the concurrent checks.
`ifndef DISTRIBUTED_DELAY_STAGE_CHAIN_TOP_MACROS_SVH
`define DISTRIBUTED_DELAY_STAGE_CHAIN_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DDSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DDSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ddsc_pkg.sv =====
// Package for the distributed delay stage chain: widths, register indexes.
// Used by the divider, the stage store and the top level.
package ddsc_pkg;

  localparam int AmtW     = 40;
  localparam int InW      = 32;
  localparam int TotW     = 48;
  localparam int CoefW    = 32;
  localparam int FracBits = 16;
  localparam int DivNumW  = 48;
  localparam int DivDenW  = 32;
  localparam int StepsW   = 8;

  typedef enum logic [1:0] {
    CFG_STAGE_COUNT   = 2'd0,
    CFG_DURATION      = 2'd1,
    CFG_INITIAL_INPUT = 2'd2
  } cfg_idx_e;

endpackage

// ===== sv/ddsc_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ddsc_pkg for the operand widths.
module ddsc_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ddsc_pkg::DivNumW-1:0] num_i,
  input  logic [ddsc_pkg::DivDenW-1:0] den_i,
  output logic                         done_o,
  output logic [ddsc_pkg::DivNumW-1:0] quot_o
);

  localparam int CntW = $clog2(ddsc_pkg::DivNumW);

  logic [ddsc_pkg::DivNumW-1:0] num_q, num_d;
  logic [ddsc_pkg::DivDenW:0]   rem_q, rem_d;
  logic [ddsc_pkg::DivDenW-1:0] den_q;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic                         busy_q, busy_d, done_q, done_d;
  logic [ddsc_pkg::DivDenW:0]   trial;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    trial  = {rem_q[ddsc_pkg::DivDenW-1:0], num_q[ddsc_pkg::DivNumW-1]};
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = num_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        num_d = {num_q[ddsc_pkg::DivNumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        num_d = {num_q[ddsc_pkg::DivNumW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(ddsc_pkg::DivNumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

// ===== sv/ddsc_mem.sv =====
// Stage amount store: one write and one registered read per cycle.
// Entries read as zero until first written after reset. Uses ddsc_pkg.
module ddsc_mem #(
  parameter int Depth = 64,
  parameter int AddrW = 6
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rd_en_i,
  input  logic [AddrW-1:0]          rd_addr_i,
  output logic [ddsc_pkg::AmtW-1:0] rd_data_o,
  input  logic                      wr_en_i,
  input  logic [AddrW-1:0]          wr_addr_i,
  input  logic [ddsc_pkg::AmtW-1:0] wr_data_i
);

  logic [ddsc_pkg::AmtW-1:0] mem [Depth];
  logic [Depth-1:0]          valid_q;
  logic [ddsc_pkg::AmtW-1:0] rd_raw_q;
  logic                      rd_valid_q;

  // Array write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_raw_q <= mem[rd_addr_i];
    end
  end

  // Written flags; reset returns every entry to zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_raw_q : '0;

endmodule

// ===== sv/distributed_delay_stage_chain_top.sv =====
// Distributed delay stage chain: Erlang cascade advanced one tick per request.
// A tick runs three divisions (sub-step count, coefficient, per-step inflow),
// then in each sub-step reads, multiplies and updates each stage in turn, stage
// zero last, and finally posts the result. The next request is taken only in
// idle, after the result is posted; a waiting result holds it back. Reset is
// asynchronous: control and running totals clear, stages read zero.
module distributed_delay_stage_chain_top #(
  parameter int MAX_STAGES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] inflow_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] outflow_o,
  output logic [39:0] contents_o,
  output logic [47:0] inflow_total_o,
  output logic [47:0] outflow_total_o
);

  `include "distributed_delay_stage_chain_top_macros.svh"

  localparam int AddrW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int AmtW  = ddsc_pkg::AmtW;
  localparam int TotW  = ddsc_pkg::TotW;
  localparam int NumW  = ddsc_pkg::DivNumW;
  localparam int DenW  = ddsc_pkg::DivDenW;
  localparam int StW   = ddsc_pkg::StepsW;
  localparam int FB    = ddsc_pkg::FracBits;
  localparam int CW    = ddsc_pkg::CoefW;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_DIVN  = 9'b000000010,
    ST_DIVC  = 9'b000000100,
    ST_DIVP  = 9'b000001000,
    ST_RD    = 9'b000010000,
    ST_MUL   = 9'b000100000,
    ST_UPD   = 9'b001000000,
    ST_ST0   = 9'b010000000,
    ST_FIN   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [6:0]  sc_q;
  logic [23:0] dur_q;
  logic [31:0] init_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q   <= 7'd30;
      dur_q  <= 24'd25600;
      init_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ddsc_pkg::CFG_STAGE_COUNT:   sc_q   <= cfg_data_i[6:0];
        ddsc_pkg::CFG_DURATION:      dur_q  <= cfg_data_i[23:0];
        ddsc_pkg::CFG_INITIAL_INPUT: init_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamped stage count and duration.
  logic [6:0]  k_cl;
  logic [23:0] len_cl;
  always_comb begin
    if (sc_q == 7'd0) begin
      k_cl = 7'd1;
    end else if (int'(sc_q) > MAX_STAGES) begin
      k_cl = 7'(MAX_STAGES);
    end else begin
      k_cl = sc_q;
    end
    len_cl = (dur_q < 24'd256) ? 24'd256 : dur_q;
  end

  // Per-tick working registers.
  logic [6:0]       k_q;
  logic [23:0]      len_q;
  logic [32:0]      acc_q;
  logic             first_q;
  logic [StW-1:0]   steps_q, sub_q;
  logic [CW-1:0]    coef_q;
  logic [32:0]      per_q;
  logic [AddrW-1:0] idx_q;
  logic             head_q;
  logic [AmtW-1:0]  x_cur_q, x_self_q, s_self_q;
  logic [55:0]      phi_q;
  logic [47:0]      plo_q;
  logic [TotW-1:0]  flow_q, in_sum_q, out_sum_q, in_tot_q;
  logic [AmtW-1:0]  total_q;
  logic             out_valid_q;
  logic [31:0]      outflow_q;
  logic [AmtW-1:0]  contents_q;

  // Divider.
  logic            div_start, div_done;
  logic [NumW-1:0] div_num, div_quot;
  logic [DenW-1:0] div_den;

  ddsc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Stage store.
  logic             mem_re, mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [AmtW-1:0]  mem_wdata, mem_rdata;

  ddsc_mem #(
    .Depth (MAX_STAGES),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (mem_re),
    .rd_addr_i (idx_q),
    .rd_data_o (mem_rdata),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata)
  );

  // Scaled flow from registered partial products: floor(coef * x / 2^32).
  logic [56:0]     s_sum;
  logic [AmtW-1:0] s_new;
  assign s_sum = {1'b0, phi_q} + 57'(plo_q >> FB);
  assign s_new = s_sum[55:16];

  // Stage update with saturation.
  logic [AmtW:0]   upd_sum;
  logic [AmtW-1:0] upd_val;
  logic [AmtW:0]   tot_sum;
  logic [StW-1:0]  steps_new;
  logic [DenW-1:0] den_c;
  logic            last_sub;
  logic [TotW:0]   in_sum_nx, out_sum_nx;
  logic [31:0]     outflow_nx;
  logic [32:0]     acc_nx;

  always_comb begin
    if (state_q == ST_ST0) begin
      upd_sum = {1'b0, x_self_q} - {1'b0, s_self_q} + (AmtW + 1)'(per_q);
    end else begin
      upd_sum = {1'b0, x_self_q} - {1'b0, s_self_q} + {1'b0, s_new};
    end
    upd_val    = upd_sum[AmtW] ? {AmtW{1'b1}} : upd_sum[AmtW-1:0];
    tot_sum    = {1'b0, total_q} + {1'b0, upd_val};
    steps_new  = div_quot[StW-1:0];
    den_c      = DenW'(len_q * steps_new);
    last_sub   = (sub_q == steps_q - 1'b1);
    acc_nx     = {1'b0, inflow_i} + (first_q ? {1'b0, init_q} : 33'd0);
    in_sum_nx  = {1'b0, in_sum_q} + (TotW + 1)'(acc_nx);
    outflow_nx = (flow_q > TotW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : flow_q[31:0];
    out_sum_nx = {1'b0, out_sum_q} + (TotW + 1)'(outflow_nx);
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign mem_re     = (state_q == ST_RD);
  assign mem_we     = (state_q == ST_ST0) || ((state_q == ST_UPD) && !head_q);
  assign mem_waddr  = (state_q == ST_ST0) ? '0 : idx_q + 1'b1;
  assign mem_wdata  = upd_val;

  // Divider operand selection.
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state_q)
      ST_IDLE: begin
        div_start = in_valid_i;
        div_num   = NumW'({len_cl, 1'b0}) + NumW'(len_cl) + NumW'({k_cl, 10'b0});
        div_den   = DenW'({len_cl, 1'b0});
      end
      ST_DIVN: begin
        div_start = div_done;
        div_num   = NumW'({k_q, 40'b0}) + NumW'(den_c >> 1);
        div_den   = den_c;
      end
      ST_DIVC: begin
        div_start = div_done;
        div_num   = NumW'(acc_q);
        div_den   = DenW'(steps_q);
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_DIVN;
      ST_DIVN: if (div_done) state_d = ST_DIVC;
      ST_DIVC: if (div_done) state_d = ST_DIVP;
      ST_DIVP: if (div_done) state_d = ST_RD;
      ST_RD:   state_d = ST_MUL;
      ST_MUL:  state_d = ST_UPD;
      ST_UPD:  state_d = (idx_q == '0) ? ST_ST0 : ST_RD;
      ST_ST0:  state_d = last_sub ? ST_FIN : ST_RD;
      ST_FIN:  if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state and running totals.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      first_q     <= 1'b1;
      in_sum_q    <= '0;
      out_sum_q   <= '0;
      out_valid_q <= 1'b0;
      head_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      // A result is posted at the end of a tick, or the taken one retires.
      if ((state_q == ST_FIN) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
        out_sum_q   <= out_sum_nx[TotW] ? {TotW{1'b1}} : out_sum_nx[TotW-1:0];
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: if (in_valid_i) begin
          first_q  <= 1'b0;
          in_sum_q <= in_sum_nx[TotW] ? {TotW{1'b1}} : in_sum_nx[TotW-1:0];
        end
        ST_DIVP: head_q <= 1'b1;
        ST_UPD:  head_q <= 1'b0;
        ST_ST0:  head_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        k_q   <= k_cl;
        len_q <= len_cl;
        acc_q <= acc_nx;
      end
      ST_DIVN: if (div_done) steps_q <= steps_new;
      ST_DIVC: if (div_done) coef_q <= div_quot[CW-1:0];
      ST_DIVP: begin
        per_q   <= div_quot[32:0];
        sub_q   <= '0;
        flow_q  <= '0;
        total_q <= '0;
        idx_q   <= AddrW'(k_q - 7'd1);
      end
      ST_MUL: begin
        x_cur_q <= mem_rdata;
        phi_q   <= coef_q * mem_rdata[AmtW-1:FB];
        plo_q   <= coef_q * mem_rdata[FB-1:0];
      end
      ST_UPD: begin
        if (head_q) begin
          flow_q <= flow_q + TotW'(s_new);
        end else if (last_sub) begin
          total_q <= tot_sum[AmtW] ? {AmtW{1'b1}} : tot_sum[AmtW-1:0];
        end
        s_self_q <= s_new;
        x_self_q <= x_cur_q;
        if (idx_q != '0) idx_q <= idx_q - 1'b1;
      end
      ST_ST0: begin
        if (last_sub) begin
          total_q <= tot_sum[AmtW] ? {AmtW{1'b1}} : tot_sum[AmtW-1:0];
        end
        sub_q <= sub_q + 1'b1;
        idx_q <= AddrW'(k_q - 7'd1);
      end
      ST_FIN: if (!out_valid_q || out_ready_i) begin
        outflow_q  <= outflow_nx;
        contents_q <= total_q;
        in_tot_q   <= in_sum_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign outflow_o       = outflow_q;
  assign contents_o      = contents_q;
  assign inflow_total_o  = in_tot_q;
  assign outflow_total_o = out_sum_q;

  // Checks on the sequencer and datapath.
  `DDSC_ASSERT_NOW(a_wr_in_range, mem_we, int'(mem_waddr) < int'(k_q), "write out of range")
  `DDSC_ASSERT_NOW(a_steps_nonzero, state_q == ST_RD, steps_q != '0, "zero sub-step count")
  `DDSC_ASSERT_NOW(a_coef_bound, state_q == ST_MUL, coef_q <= 32'h8000_0000, "coef too large")
  `DDSC_ASSERT_NEXT(a_fin_delivers, state_q == ST_FIN && state_d == ST_IDLE, out_valid_o, "lost")

endmodule
